// ===== hdl/ile_pkg.sv =====
// Indexed list engine package: opcodes, status codes, cell commands, FSM states.
// No dependencies; imported by all hdl modules of the block.
package ile_pkg;

  localparam int IDX_BITS = 10;  // cell index width, covers capacities up to 1024

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_SET    = 3'd3,
    OP_DELETE = 3'd4,
    OP_CLEAR  = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOROOM = 2'd1,
    STAT_EMPTY  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_WRITE,
    CM_INSERT,
    CM_SHIFT
  } cell_mode_t;

  typedef enum logic {
    S_IDLE,
    S_SHIFT
  } state_t;

  // broadcast to every cell
  typedef struct packed {
    cell_mode_t            mode;
    logic [IDX_BITS-1:0]   pos;  // target index / first index of shift
    logic [IDX_BITS-1:0]   lo;   // first index of zero fill
  } cell_cmd_t;

endpackage

// ===== hdl/ile_cell.sv =====
// One list entry of the cell chain: write, zero fill, shift up from the left
// neighbor or shift down from the right neighbor. Depends on ile_pkg.
module ile_cell import ile_pkg::*; #(
  parameter int VALUE_BITS = 32,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [VALUE_BITS-1:0] left,
  input  logic [VALUE_BITS-1:0] right,
  output logic [VALUE_BITS-1:0] data
);

  localparam logic [IDX_BITS-1:0] IDX = IDX_BITS'(INDEX);

  always_ff @(posedge clk) begin
    case (cmd.mode)
      CM_WRITE: begin
        if (IDX == cmd.pos) begin
          data <= value;
        end else if (IDX >= cmd.lo && IDX < cmd.pos) begin
          data <= '0;
        end
      end
      CM_INSERT: begin
        if (IDX == cmd.pos) begin
          data <= value;
        end else if (IDX > cmd.pos) begin
          data <= left;
        end
      end
      CM_SHIFT: begin
        if (IDX >= cmd.pos) begin
          data <= right;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

// ===== hdl/ile_ctrl.sv =====
// Indexed list engine controller: handshake, length register, opcode decode,
// delete shift sequencer and result register. Depends on ile_pkg.
module ile_ctrl import ile_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32,
  parameter int IW         = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [55:0]           s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [47:0]           m_tdata,
  output logic [IW-1:0]         rd_index,
  input  logic [VALUE_BITS-1:0] rd_data,
  output cell_cmd_t             cmd,
  output logic [VALUE_BITS-1:0] value
);

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int CW    = (LEN_W > 7 ? LEN_W : 7) + 1;
  localparam logic [CW-1:0] CAP_X = CW'(CAPACITY);

  state_t state, state_next;
  logic [LEN_W-1:0] used, used_next;
  logic [6:0] shift_left, shift_left_next;
  logic [IDX_BITS-1:0] shift_pos, shift_pos_next;
  logic [1:0] status_out;
  logic [31:0] popped_out;
  logic [6:0] length_out;

  opcode_t op;
  logic [6:0] pos, cnt;
  logic [CW-1:0] pos_x, cnt_x, used_x;
  logic accept;
  status_t status;
  logic [31:0] popped;

  assign op     = opcode_t'(s_tdata[2:0]);
  assign pos    = s_tdata[9:3];
  assign value  = VALUE_BITS'(s_tdata[41:10]);
  assign cnt    = s_tdata[48:42];
  assign pos_x  = CW'(pos);
  assign cnt_x  = CW'(cnt);
  assign used_x = CW'(used);

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign rd_index = IW'(used - LEN_W'(1));
  assign m_tdata  = {7'd0, length_out, popped_out, status_out};

  always_comb begin
    state_next      = state;
    used_next       = used;
    shift_left_next = shift_left;
    shift_pos_next  = shift_pos;
    status          = STAT_OK;
    popped          = '0;
    cmd.mode        = CM_HOLD;
    cmd.pos         = shift_pos;
    cmd.lo          = shift_pos;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_PUSH: begin
              if (used_x >= CAP_X) begin
                status = STAT_NOROOM;
              end else begin
                cmd.mode  = CM_WRITE;
                cmd.pos   = IDX_BITS'(used);
                cmd.lo    = IDX_BITS'(used);
                used_next = used + LEN_W'(1);
              end
            end
            OP_POP: begin
              if (used == '0) begin
                status = STAT_EMPTY;
              end else begin
                used_next = used - LEN_W'(1);
                popped    = 32'(rd_data);
              end
            end
            OP_INSERT, OP_SET: begin
              if (pos_x >= used_x) begin
                if (pos_x >= CAP_X) begin
                  status = STAT_NOROOM;
                end else begin
                  cmd.mode  = CM_WRITE;
                  cmd.pos   = IDX_BITS'(pos);
                  cmd.lo    = IDX_BITS'(used);
                  used_next = LEN_W'(pos_x + CW'(1));
                end
              end else if (op == OP_SET) begin
                cmd.mode = CM_WRITE;
                cmd.pos  = IDX_BITS'(pos);
                cmd.lo   = IDX_BITS'(pos);
              end else if (used_x >= CAP_X) begin
                status = STAT_NOROOM;
              end else begin
                cmd.mode  = CM_INSERT;
                cmd.pos   = IDX_BITS'(pos);
                cmd.lo    = IDX_BITS'(pos);
                used_next = used + LEN_W'(1);
              end
            end
            OP_DELETE: begin
              if (pos_x < used_x && cnt != '0) begin
                if (pos_x + cnt_x >= used_x) begin
                  used_next = LEN_W'(pos_x);
                end else begin
                  used_next       = LEN_W'(used_x - cnt_x);
                  cmd.mode        = CM_SHIFT;
                  cmd.pos         = IDX_BITS'(pos);
                  cmd.lo          = IDX_BITS'(pos);
                  shift_pos_next  = IDX_BITS'(pos);
                  shift_left_next = cnt - 7'd1;
                  if (cnt != 7'd1) begin
                    state_next = S_SHIFT;
                  end
                end
              end
            end
            OP_CLEAR: begin
              used_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        cmd.mode        = CM_SHIFT;
        shift_left_next = shift_left - 7'd1;
        if (shift_left == 7'd1) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      used     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift_left <= shift_left_next;
    shift_pos  <= shift_pos_next;
    if (accept) begin
      status_out <= status;
      popped_out <= popped;
      length_out <= 7'(used_next);
    end
  end

endmodule

// ===== hdl/indexed_list_engine.sv =====
// Indexed list engine top: bounded ordered list held in a chain of cells.
// Result: registered; m_tvalid rises in the cycle after the transaction is accepted.
// Throughput: one transaction per cycle while m_tready takes each result; a delete
// that moves the tail shifts it down one cell per cycle until remove_count
// entries are gone, and input is blocked while the shift runs.
// Reset (rst, synchronous) empties the list; entry contents are not cleared.
module indexed_list_engine import ile_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // opcode[2:0], position[9:3], item_value[41:10],
                                 // remove_count[48:42]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // status[1:0], popped_value[33:2], list_length[40:34]
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  cell_cmd_t cmd;
  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] cells [CAPACITY];
  logic [IW-1:0] rd_index;
  logic [VALUE_BITS-1:0] rd_data;

  ile_ctrl #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS),
    .IW        (IW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .rd_index(rd_index),
    .rd_data (rd_data),
    .cmd     (cmd),
    .value   (value)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cells[i];
    end else begin : g_inner
      assign right = cells[i+1];
    end
    ile_cell #(
      .VALUE_BITS(VALUE_BITS),
      .INDEX     (i)
    ) u_cell (
      .clk  (clk),
      .cmd  (cmd),
      .value(value),
      .left (left),
      .right(right),
      .data (cells[i])
    );
  end

  // tail read for pop
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rd_index == IW'(i)) begin
        rd_data = cells[i];
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tready))
    else $error("input accepted while result pending");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted transaction produced no result");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == STAT_EMPTY) |->
      (m_tdata[33:2] == 32'd0 && m_tdata[40:34] == 7'd0))
    else $error("empty pop result inconsistent");

endmodule
